### rtl/scw_pkg.sv
`default_nettype none
// ============================================================================
// scw_pkg
// Shared types, widths and fixed-point constants of the sine contrast
// waveshaper.
// ============================================================================
package scw_pkg;

  // port widths
  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 7;
  localparam int LEVEL_CNT = 1 << LEVEL_W;
  localparam int LEVEL_MAX = 100;
  localparam int COEF_W    = 16;   // unsigned Q0.16 contrast factor
  localparam int COEF_ONE  = 65536;
  localparam int PERCENT   = 100;

  // datapath widths
  localparam int PROD1_W = 34;     // sample times pi/2 in Q16
  localparam int D_W     = 18;     // Q1.16 angle d
  localparam int ANGLE_W = 20;     // Q3.16 angle into the sine unit
  localparam int SINE_W  = 18;     // Q1.16 sine
  localparam int CP_W    = 35;     // contrast times sine product
  localparam int CS_W    = 19;     // Q2.16 contrast term
  localparam int OP_W    = 34;     // sine times output gain

  // sine unit internals
  localparam int RED_W  = 36;      // Q30 angle before folding
  localparam int FOLD_W = 32;      // Q30 angle in [-pi/2, pi/2]
  localparam int X2_W   = 32;      // Q30 square of the folded angle
  localparam int T_W    = 31;      // Q30 horner accumulator, in (0, 1]
  localparam int V_W    = 32;      // product handed to a constant divide
  localparam int QE_W   = 30;      // estimated quotient
  localparam int REM_W  = 38;      // remainder arithmetic width
  localparam int MV_W   = 32;      // magnitude of the Q30 sine
  localparam int RM_W   = 17;      // magnitude of the Q16 sine

  localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
  localparam logic [14:0] OUT_GAIN    = 15'd32767;

  localparam logic signed [RED_W-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [RED_W-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [RED_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic [T_W-1:0]          Q30_ONE     = 31'h4000_0000;
  localparam logic [MV_W:0]           Q30_RND     = 33'd8192;

  // taylor series through x^11, horner order
  localparam int HORNER_STEPS = 5;
  localparam logic [6:0] HORNER_DEN [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  // floor(2^32 / den): quotient estimate low by at most one
  localparam logic [QE_W-1:0] HORNER_RECIP [HORNER_STEPS] = '{
    30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72),
    30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20),
    30'((64'd1 << 32) / 64'd6)
  };

  // reduce, fold, square, three per horner step, four to scale and round
  localparam int SINE_LAT = 3 + 3 * HORNER_STEPS + 4;
  // angle d travels alongside the first sine and two contrast stages
  localparam int D_DLY = SINE_LAT + 3;
  // input sample travels to the final mux
  localparam int X_DLY = 2 * SINE_LAT + 6;

  typedef struct packed {
    logic              bypass;
    logic [COEF_W-1:0] coef;
  } scw_cfg_t;

  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] sample;
  } scw_beat_t;

  // contrast percent to Q0.16, saturated at full scale
  function automatic logic [COEF_W-1:0] coef_of(input int lvl);
    int l;
    int v;
    l = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    v = (l * COEF_ONE + PERCENT / 2) / PERCENT;
    if (v > COEF_ONE - 1) v = COEF_ONE - 1;
    return COEF_W'(v);
  endfunction

endpackage
`default_nettype wire

### rtl/scw_in_if.sv
`default_nettype none
// ============================================================================
// scw_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ============================================================================
interface scw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [scw_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

### rtl/scw_out_if.sv
`default_nettype none
// ============================================================================
// scw_out_if
// Result sample channel: valid/ready handshake with one signed sample.
// ============================================================================
interface scw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scw_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

### rtl/sine_contrast_waveshaper.sv
`default_nettype none
// ============================================================================
// sine_contrast_waveshaper
// Shapes each audio sample x to sin(d + c*sin(4d)) * 32767, d = (pi/2)x/32768.
//
// in_ch carries one signed 16-bit sample per beat, out_ch one shaped sample
// per beat, in order, one result for every input beat. cfg_we/cfg_wdata
// write the contrast in percent (values above 100 act as 100); write it only
// while no beat is in flight. Contrast 0 passes samples through unchanged.
// Throughput is one beat per clock while out_ch takes beats. The datapath
// is a 51-stage pipeline: two sine units of 22 stages each (one per horner
// step of the series takes three stages: multiply, reciprocal multiply,
// correction), plus seven stages of angle, contrast and gain math. The
// output register and a one-entry skid let the pipeline keep going for one
// more beat while out_ch stalls; after that in_ch.ready drops until out_ch
// takes a beat. Reset empties the pipeline and sets contrast 0.
// ============================================================================
module sine_contrast_waveshaper (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  scw_in_if.sink                           in_ch,
  scw_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [scw_pkg::LEVEL_W-1:0] cfg_wdata
);

  logic               adv;
  scw_pkg::scw_cfg_t  cfg;
  scw_pkg::scw_beat_t beat;

  logic signed [scw_pkg::SAMPLE_W-1:0] x_pipe_r [scw_pkg::X_DLY];
  logic signed [scw_pkg::D_W-1:0]      d_pipe_r [scw_pkg::D_DLY];

  logic                                 vld1_r;
  logic signed [scw_pkg::PROD1_W-1:0]   p1_nxt;
  logic signed [scw_pkg::PROD1_W-1:0]   p1_r;
  logic                                 vld2_r;
  logic signed [scw_pkg::PROD1_W-1:0]   dsum;
  logic signed [scw_pkg::D_W-1:0]       d_nxt;
  logic signed [scw_pkg::ANGLE_W-1:0]   a4_r;

  logic                                 s1_vld;
  logic signed [scw_pkg::SINE_W-1:0]    s4;
  logic                                 vld_c1_r;
  logic signed [scw_pkg::CP_W-1:0]      cp_nxt;
  logic signed [scw_pkg::CP_W-1:0]      cp_r;
  logic                                 vld_c2_r;
  logic signed [scw_pkg::CP_W-1:0]      csum;
  logic signed [scw_pkg::CS_W-1:0]      cs_r;
  logic                                 vld_c3_r;
  logic signed [scw_pkg::ANGLE_W-1:0]   a2_nxt;
  logic signed [scw_pkg::ANGLE_W-1:0]   a2_r;

  logic                                 s2_vld;
  logic signed [scw_pkg::SINE_W-1:0]    y;
  logic                                 vld_o1_r;
  logic signed [scw_pkg::OP_W-1:0]      op_nxt;
  logic signed [scw_pkg::OP_W-1:0]      op_r;
  logic                                 vld_o2_r;
  logic signed [scw_pkg::OP_W-1:0]      osum;
  logic signed [scw_pkg::SAMPLE_W-1:0]  res_nxt;
  logic signed [scw_pkg::SAMPLE_W-1:0]  res_r;

  scw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_ch.ready = adv;

  // valid bits of the top-level stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r   <= 1'b0;
      vld2_r   <= 1'b0;
      vld_c1_r <= 1'b0;
      vld_c2_r <= 1'b0;
      vld_c3_r <= 1'b0;
      vld_o1_r <= 1'b0;
      vld_o2_r <= 1'b0;
    end else if (adv) begin
      vld1_r   <= in_ch.valid;
      vld2_r   <= vld1_r;
      vld_c1_r <= s1_vld;
      vld_c2_r <= vld_c1_r;
      vld_c3_r <= vld_c2_r;
      vld_o1_r <= s2_vld;
      vld_o2_r <= vld_o1_r;
    end
  end

  // delay lines for the raw sample and the angle d
  always_ff @(posedge clk) begin
    if (adv) begin
      x_pipe_r[0] <= in_ch.sample_in;
      for (int k = 1; k < scw_pkg::X_DLY; k++) begin
        x_pipe_r[k] <= x_pipe_r[k-1];
      end
      d_pipe_r[0] <= d_nxt;
      for (int k = 1; k < scw_pkg::D_DLY; k++) begin
        d_pipe_r[k] <= d_pipe_r[k-1];
      end
    end
  end

  // stage 1: sample times pi/2 in Q16
  assign p1_nxt = in_ch.sample_in * $signed({1'b0, scw_pkg::HALF_PI_Q16});

  // stage 2: divide by 32768 toward zero, angle 4d for the first sine
  assign dsum  = p1_r + (p1_r[scw_pkg::PROD1_W-1] ? scw_pkg::PROD1_W'(32767)
                                                  : scw_pkg::PROD1_W'(0));
  assign d_nxt = dsum[32:15];

  // contrast term: c * sin(4d) / 65536 toward zero, then added to d
  assign cp_nxt = $signed({1'b0, cfg.coef}) * s4;
  assign csum   = cp_r + (cp_r[scw_pkg::CP_W-1] ? scw_pkg::CP_W'(65535)
                                                : scw_pkg::CP_W'(0));
  assign a2_nxt = scw_pkg::ANGLE_W'(d_pipe_r[scw_pkg::D_DLY-1]) + scw_pkg::ANGLE_W'(cs_r);

  // output gain: y * 32767 / 65536 toward zero, or the raw sample in bypass
  assign op_nxt  = y * $signed({1'b0, scw_pkg::OUT_GAIN});
  assign osum    = op_r + (op_r[scw_pkg::OP_W-1] ? scw_pkg::OP_W'(65535)
                                                 : scw_pkg::OP_W'(0));
  assign res_nxt = cfg.bypass ? x_pipe_r[scw_pkg::X_DLY-1] : osum[31:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p1_nxt;
      a4_r  <= {d_nxt, 2'b00};
      cp_r  <= cp_nxt;
      cs_r  <= csum[34:16];
      a2_r  <= a2_nxt;
      op_r  <= op_nxt;
      res_r <= res_nxt;
    end
  end

  scw_sine u_sine_4d (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vld2_r),
    .angle   (a4_r),
    .out_vld (s1_vld),
    .sine    (s4)
  );

  scw_sine u_sine_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vld_c3_r),
    .angle   (a2_r),
    .out_vld (s2_vld),
    .sine    (y)
  );

  assign beat.vld    = vld_o2_r;
  assign beat.sample = res_r;

  scw_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### rtl/scw_cfg.sv
`default_nettype none
// ============================================================================
// scw_cfg
// Contrast register: percent written, stored as the saturated Q0.16 factor.
// ============================================================================
module scw_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [scw_pkg::LEVEL_W-1:0]  cfg_wdata,
  output scw_pkg::scw_cfg_t                 cfg
);

  logic [scw_pkg::COEF_W-1:0] coef_tab [scw_pkg::LEVEL_CNT];
  logic [scw_pkg::COEF_W-1:0] coef_r;
  logic [scw_pkg::COEF_W-1:0] coef_nxt;

  // constant percent to factor table, levels above 100 saturate
  for (genvar g = 0; g < scw_pkg::LEVEL_CNT; g++) begin : g_tab
    assign coef_tab[g] = scw_pkg::coef_of(g);
  end

  assign coef_nxt = coef_tab[cfg_wdata];

  // register, reset to bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      coef_r <= coef_nxt;
    end
  end

  // a zero factor only comes from a zero level
  assign cfg.coef   = coef_r;
  assign cfg.bypass = (coef_r == '0);

endmodule
`default_nettype wire

### rtl/scw_sine.sv
`default_nettype none
// ============================================================================
// scw_sine
// Pipelined fixed-point sine: Q3.16 angle in, Q1.16 sine out. Range
// reduction, Q30 taylor series by horner steps, rounding to Q16.
// ============================================================================
module scw_sine (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_vld,
  input  wire logic signed [scw_pkg::ANGLE_W-1:0] angle,
  output logic                                    out_vld,
  output logic signed [scw_pkg::SINE_W-1:0]       sine
);

  typedef struct packed {
    logic signed [scw_pkg::FOLD_W-1:0] af;
    logic [scw_pkg::X2_W-1:0]          x2;
  } sq_pair_t;

  localparam int LAST = scw_pkg::HORNER_STEPS - 1;

  logic [scw_pkg::SINE_LAT-1:0] vld_r;

  logic signed [scw_pkg::RED_W-1:0]  a_ext;
  logic signed [scw_pkg::RED_W-1:0]  red_nxt;
  logic signed [scw_pkg::RED_W-1:0]  red_r;
  logic signed [scw_pkg::RED_W-1:0]  fold_full;
  logic signed [scw_pkg::FOLD_W-1:0] fold_r;
  logic signed [2*scw_pkg::FOLD_W-1:0] sq_full;
  sq_pair_t                          sq_r;

  sq_pair_t                 hp_a_r [scw_pkg::HORNER_STEPS];
  sq_pair_t                 hp_b_r [scw_pkg::HORNER_STEPS];
  sq_pair_t                 hp_c_r [scw_pkg::HORNER_STEPS];
  logic [scw_pkg::V_W-1:0]  hv_a_r [scw_pkg::HORNER_STEPS];
  logic [scw_pkg::V_W-1:0]  hv_b_r [scw_pkg::HORNER_STEPS];
  logic [scw_pkg::QE_W-1:0] hq_b_r [scw_pkg::HORNER_STEPS];
  logic [scw_pkg::T_W-1:0]  ht_c_r [scw_pkg::HORNER_STEPS];

  logic signed [63:0]              pm_nxt;
  logic signed [63:0]              pm_r;
  logic [63:0]                     pm_mag;
  logic [scw_pkg::MV_W-1:0]        mv_r;
  logic                            neg_r;
  logic [scw_pkg::MV_W:0]          rsum;
  logic [scw_pkg::RM_W-1:0]        rm_r;
  logic                            neg2_r;
  logic signed [scw_pkg::SINE_W-1:0] sine_nxt;
  logic signed [scw_pkg::SINE_W-1:0] sine_r;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[scw_pkg::SINE_LAT-2:0], in_vld};
    end
  end

  // stage 1: scale to Q30, one add of 2pi brings it into [-pi, pi]
  assign a_ext = {{(scw_pkg::RED_W - scw_pkg::ANGLE_W - 14){angle[scw_pkg::ANGLE_W-1]}},
                  angle, 14'd0};

  always_comb begin
    if (a_ext > scw_pkg::Q30_PI) begin
      red_nxt = a_ext - scw_pkg::Q30_TWO_PI;
    end else if (a_ext < -scw_pkg::Q30_PI) begin
      red_nxt = a_ext + scw_pkg::Q30_TWO_PI;
    end else begin
      red_nxt = a_ext;
    end
  end

  // stage 2: fold into [-pi/2, pi/2]
  always_comb begin
    if (red_r > scw_pkg::Q30_HALF_PI) begin
      fold_full = scw_pkg::Q30_PI - red_r;
    end else if (red_r < -scw_pkg::Q30_HALF_PI) begin
      fold_full = -scw_pkg::Q30_PI - red_r;
    end else begin
      fold_full = red_r;
    end
  end

  // stage 3: square, back to Q30
  assign sq_full = fold_r * fold_r;

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      fold_r  <= fold_full[scw_pkg::FOLD_W-1:0];
      sq_r.af <= fold_r;
      sq_r.x2 <= sq_full[61:30];
    end
  end

  // horner steps: t = 1 - ((t * x2) >> 30) / den, three stages each
  for (genvar i = 0; i < scw_pkg::HORNER_STEPS; i++) begin : g_horner
    sq_pair_t                   pin;
    logic [scw_pkg::T_W-1:0]    tin;
    logic [scw_pkg::T_W+scw_pkg::X2_W-1:0]  tp;
    logic [scw_pkg::V_W+scw_pkg::QE_W-1:0]  rp;
    logic [scw_pkg::REM_W-1:0]  qd;
    logic [scw_pkg::REM_W-1:0]  rem;
    logic [scw_pkg::T_W-1:0]    q;

    if (i == 0) begin : g_first
      assign pin = sq_r;
      assign tin = scw_pkg::Q30_ONE;
    end else begin : g_next
      assign pin = hp_c_r[i-1];
      assign tin = ht_c_r[i-1];
    end

    // product of accumulator and square
    assign tp = (scw_pkg::T_W+scw_pkg::X2_W)'(tin) * (scw_pkg::T_W+scw_pkg::X2_W)'(pin.x2);
    // quotient estimate by reciprocal
    assign rp = (scw_pkg::V_W+scw_pkg::QE_W)'(hv_a_r[i])
              * (scw_pkg::V_W+scw_pkg::QE_W)'(scw_pkg::HORNER_RECIP[i]);
    // correct the estimate by one where the remainder reaches the divisor
    assign qd  = scw_pkg::REM_W'(hq_b_r[i]) * scw_pkg::REM_W'(scw_pkg::HORNER_DEN[i]);
    assign rem = scw_pkg::REM_W'(hv_b_r[i]) - qd;
    assign q   = scw_pkg::T_W'(hq_b_r[i])
               + scw_pkg::T_W'(rem >= scw_pkg::REM_W'(scw_pkg::HORNER_DEN[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        hp_a_r[i] <= pin;
        hv_a_r[i] <= tp[61:30];
        hp_b_r[i] <= hp_a_r[i];
        hv_b_r[i] <= hv_a_r[i];
        hq_b_r[i] <= rp[61:32];
        hp_c_r[i] <= hp_b_r[i];
        ht_c_r[i] <= scw_pkg::Q30_ONE - q;
      end
    end
  end

  // final scale: angle times series, truncated toward zero
  assign pm_nxt = 64'($signed(hp_c_r[LAST].af)) * 64'($signed({1'b0, ht_c_r[LAST]}));
  assign pm_mag = pm_r[63] ? 64'(-pm_r) : 64'(pm_r);
  // round the Q30 magnitude to Q16, half away from zero
  assign rsum   = {1'b0, mv_r} + scw_pkg::Q30_RND;
  assign sine_nxt = neg2_r ? -$signed({1'b0, rm_r}) : $signed({1'b0, rm_r});

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r   <= pm_nxt;
      mv_r   <= pm_mag[61:30];
      neg_r  <= pm_r[63];
      rm_r   <= rsum[30:14];
      neg2_r <= neg_r;
      sine_r <= sine_nxt;
    end
  end

  assign out_vld = vld_r[scw_pkg::SINE_LAT-1];
  assign sine    = sine_r;

endmodule
`default_nettype wire

### rtl/scw_obuf.sv
`default_nettype none
// ============================================================================
// scw_obuf
// Output register plus skid entry; holds the pipeline only when both are full.
// ============================================================================
module scw_obuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire scw_pkg::scw_beat_t beat,
  output logic                    adv,
  scw_out_if.source               out_ch
);

  logic                                out_vld_r;
  logic                                out_vld_nxt;
  logic signed [scw_pkg::SAMPLE_W-1:0] out_data_r;
  logic signed [scw_pkg::SAMPLE_W-1:0] out_data_nxt;
  logic                                sk_vld_r;
  logic                                sk_vld_nxt;
  logic signed [scw_pkg::SAMPLE_W-1:0] sk_data_r;
  logic signed [scw_pkg::SAMPLE_W-1:0] sk_data_nxt;
  logic                                load;
  logic                                emit;

  // pipeline moves whenever the skid entry is free
  assign adv  = !sk_vld_r;
  assign emit = beat.vld && adv;
  assign load = !out_vld_r || out_ch.ready;

  // output register refills from skid first, then from the pipeline
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    sk_vld_nxt   = sk_vld_r;
    sk_data_nxt  = sk_data_r;
    if (load) begin
      if (sk_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = sk_data_r;
        sk_vld_nxt   = 1'b0;
      end else begin
        out_vld_nxt  = emit;
        out_data_nxt = beat.sample;
      end
    end else if (emit) begin
      sk_vld_nxt  = 1'b1;
      sk_data_nxt = beat.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sk_vld_r  <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sk_data_r  <= sk_data_nxt;
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.sample_out = out_data_r;

endmodule
`default_nettype wire
